/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files of the project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the clock after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same clock as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hdl/mrws_pkg.sv */
// Shared types, constants and the CRC-16/MODBUS byte step for the Modbus RTU
// register-write slave. Depends on nothing.
package mrws_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned HEAD_BYTES  = 6;
  localparam int unsigned JOB_DEPTH   = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FUNC_READ     = 8'h03;
  localparam logic [7:0] FUNC_WRITE    = 8'h06;
  localparam logic [7:0] EXCEPTION_BIT = 8'h80;

  localparam logic [7:0] ERR_FUNCTION = 8'h01;
  localparam logic [7:0] ERR_REGISTER = 8'h02;
  localparam logic [7:0] ERR_DATA     = 8'h03;

  localparam logic [15:0] REG_MODE  = 16'd0;
  localparam logic [15:0] REG_SPEED = 16'd666;

  localparam logic [15:0] CMD_START  = 16'd1;
  localparam logic [15:0] CMD_STOP   = 16'd2;
  localparam logic [15:0] CMD_PREOP  = 16'd80;
  localparam logic [15:0] CMD_QUIET1 = 16'd81;
  localparam logic [15:0] CMD_QUIET2 = 16'd82;

  localparam logic [7:0]         NODE_ADDR_RESET = 8'd7;
  localparam logic signed [15:0] SETPOINT_RESET  = 16'sd5000;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_PREOP = 2'd1,
    MODE_OPER  = 2'd2,
    MODE_STOP  = 2'd3
  } node_mode_e;

  // One reply waiting to be sent: six header bytes plus the state snapshot.
  typedef struct packed {
    logic [HEAD_BYTES-1:0][7:0] head;
    node_mode_e                 mode;
    logic signed [15:0]         setpoint;
  } job_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* hdl/mrws_queue.sv */
// Small job queue between the frame decoder and the reply sender.
// Depends on mrws_pkg for the job type.
module mrws_queue #(
  parameter int unsigned Depth = mrws_pkg::JOB_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mrws_pkg::job_t job_i,
  input  logic           pop_i,
  output mrws_pkg::job_t job_o,
  output logic           valid_o,
  output logic           full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mrws_pkg::job_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o   = entries_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(Depth));

endmodule

/* hdl/mrws_front.sv */
// Front end: gathers frame bytes, runs the receive CRC and decodes a complete
// frame into a reply job and new node state. Depends on mrws_pkg.
module mrws_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     rx_byte_i,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_data_i,
  output logic           job_push_o,
  output mrws_pkg::job_t job_o
);

  localparam logic [2:0] PosLast = 3'(mrws_pkg::FRAME_BYTES - 1);
  localparam logic [2:0] PosHead = 3'(mrws_pkg::HEAD_BYTES);

  logic [7:0]  store_q [mrws_pkg::FRAME_BYTES];
  logic [7:0]  frame   [mrws_pkg::FRAME_BYTES];
  logic [2:0]  pos_q;
  logic [15:0] crc_q;
  logic [7:0]  node_addr_q;
  mrws_pkg::node_mode_e mode_q, mode_d;
  logic signed [15:0]   sp_q, sp_d;

  logic        frame_done;
  logic        reply, err;
  logic [7:0]  code;
  logic [15:0] reg_addr, data;

  assign frame_done = accept_i && (pos_q == PosLast);

  always_comb begin
    for (int i = 0; i < int'(mrws_pkg::FRAME_BYTES) - 1; i++) begin
      frame[i] = store_q[i];
    end
    frame[mrws_pkg::FRAME_BYTES-1] = rx_byte_i;
    reg_addr = {frame[2], frame[3]};
    data     = {frame[4], frame[5]};

    reply  = 1'b0;
    err    = 1'b0;
    code   = 8'h00;
    mode_d = mode_q;
    sp_d   = sp_q;

    if (frame[6] == crc_q[7:0] && frame[7] == crc_q[15:8] && frame[0] == node_addr_q) begin
      if (frame[1] == mrws_pkg::FUNC_READ) begin
        reply = 1'b0;
      end else if (frame[1] != mrws_pkg::FUNC_WRITE) begin
        err  = 1'b1;
        code = mrws_pkg::ERR_FUNCTION;
      end else if (reg_addr == mrws_pkg::REG_MODE) begin
        case (data)
          mrws_pkg::CMD_START: begin
            mode_d = mrws_pkg::MODE_OPER;
            reply  = 1'b1;
          end
          mrws_pkg::CMD_STOP: begin
            mode_d = mrws_pkg::MODE_STOP;
            reply  = 1'b1;
          end
          mrws_pkg::CMD_PREOP: begin
            mode_d = mrws_pkg::MODE_PREOP;
            reply  = 1'b1;
          end
          mrws_pkg::CMD_QUIET1, mrws_pkg::CMD_QUIET2: begin
            reply = 1'b0;
          end
          default: begin
            err  = 1'b1;
            code = mrws_pkg::ERR_DATA;
          end
        endcase
      end else if (reg_addr == mrws_pkg::REG_SPEED) begin
        sp_d  = signed'(data);
        reply = 1'b1;
      end else begin
        err  = 1'b1;
        code = mrws_pkg::ERR_REGISTER;
      end
    end

    // An exception reply carries the code in the register field.
    if (err) begin
      job_o.head[0] = frame[0];
      job_o.head[1] = frame[1] | mrws_pkg::EXCEPTION_BIT;
      job_o.head[2] = 8'h00;
      job_o.head[3] = code;
      job_o.head[4] = 8'h00;
      job_o.head[5] = 8'h00;
    end else begin
      for (int i = 0; i < int'(mrws_pkg::HEAD_BYTES); i++) begin
        job_o.head[i] = frame[i];
      end
    end
    job_o.mode     = mode_d;
    job_o.setpoint = sp_d;
  end

  assign job_push_o = frame_done && (reply || err);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= mrws_pkg::CRC_INIT;
      node_addr_q <= mrws_pkg::NODE_ADDR_RESET;
      mode_q      <= mrws_pkg::MODE_INIT;
      sp_q        <= mrws_pkg::SETPOINT_RESET;
    end else begin
      if (cfg_we_i) begin
        node_addr_q <= cfg_data_i;
      end
      if (accept_i) begin
        if (pos_q == PosLast) begin
          pos_q  <= '0;
          crc_q  <= mrws_pkg::CRC_INIT;
          mode_q <= mode_d;
          sp_q   <= sp_d;
        end else begin
          pos_q <= pos_q + 1'b1;
          if (pos_q < PosHead) begin
            crc_q <= mrws_pkg::crc16_byte(crc_q, rx_byte_i);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      store_q[pos_q] <= rx_byte_i;
    end
  end

endmodule

/* hdl/mrws_back.sv */
// Back end: sends the job at the head of the queue byte by byte, appending
// the CRC, through a one-entry output register. Depends on mrws_pkg.
module mrws_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  mrws_pkg::job_t     job_i,
  output logic               job_pop_o,
  input  logic               pop,
  output logic               empty,
  output logic [7:0]         tx_byte_o,
  output logic               last_byte_o,
  output logic [1:0]         node_state_o,
  output logic signed [15:0] speed_setpoint_o
);

  localparam logic [2:0] IdxCrcLo = 3'(mrws_pkg::HEAD_BYTES);
  localparam logic [2:0] IdxLast  = 3'(mrws_pkg::FRAME_BYTES - 1);

  logic [2:0]  idx_q;
  logic [15:0] crc_q;
  logic        out_valid_q;
  logic [7:0]  tx_q, tx_d;
  logic        last_q;
  mrws_pkg::node_mode_e mode_q;
  logic signed [15:0]   sp_q;
  logic        advance;

  assign advance   = job_valid_i && (!out_valid_q || pop);
  assign job_pop_o = advance && (idx_q == IdxLast);

  always_comb begin
    case (idx_q)
      3'd0:    tx_d = job_i.head[0];
      3'd1:    tx_d = job_i.head[1];
      3'd2:    tx_d = job_i.head[2];
      3'd3:    tx_d = job_i.head[3];
      3'd4:    tx_d = job_i.head[4];
      3'd5:    tx_d = job_i.head[5];
      3'd6:    tx_d = crc_q[7:0];
      default: tx_d = crc_q[15:8];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      crc_q       <= mrws_pkg::CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        if (idx_q == IdxLast) begin
          idx_q <= '0;
          crc_q <= mrws_pkg::CRC_INIT;
        end else begin
          idx_q <= idx_q + 1'b1;
          if (idx_q < IdxCrcLo) begin
            crc_q <= mrws_pkg::crc16_byte(crc_q, tx_d);
          end
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      tx_q   <= tx_d;
      last_q <= (idx_q == IdxLast);
      mode_q <= job_i.mode;
      sp_q   <= job_i.setpoint;
    end
  end

  assign empty            = !out_valid_q;
  assign tx_byte_o        = tx_q;
  assign last_byte_o      = last_q;
  assign node_state_o     = mode_q;
  assign speed_setpoint_o = sp_q;

endmodule

/* hdl/modbus_rtu_write_register_slave.sv */
// Top level of the Modbus RTU register-write slave: front end, job queue and
// reply sender. Depends on mrws_pkg, mrws_front, mrws_queue and mrws_back.
//
//   Channel   Direction  Handshake              Payload
//   receive   in         push / full            rx_byte_i
//   reply     out        pop / empty            tx_byte_o, last_byte_o,
//                                               node_state_o, speed_setpoint_o
//   config    in         node_address_we_i      node_address_i
//
// One received byte is taken per cycle while full is low; the byte-wide CRC
// step in the front end sets that rate. A reply, once started, leaves at one
// byte per cycle while pop is high. Reset leaves the slave ready at once,
// with no clearing pass. Receive stalls (full high) only while the job queue
// holds JobDepth replies that the consumer has not yet drained.

module modbus_rtu_write_register_slave #(
  parameter int unsigned JobDepth = mrws_pkg::JOB_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         tx_byte_o,
  output logic               last_byte_o,
  output logic [1:0]         node_state_o,
  output logic signed [15:0] speed_setpoint_o,
  input  logic               node_address_we_i,
  input  logic [7:0]         node_address_i
);

  // A received byte is a transaction when push is high and the queue has
  // room. The front end only ever produces a job on such a transaction, so
  // the queue can never overflow.
  logic           accept;
  logic           job_push, job_pop, job_valid, q_full;
  mrws_pkg::job_t job_in, job_head;

  assign accept = push && !q_full;
  assign full   = q_full;

  // The front end holds the frame bytes and running CRC, and on the eighth
  // byte decides on an echo, an exception reply or silence, updating the
  // node mode and setpoint there and then.
  mrws_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (node_address_we_i),
    .cfg_data_i (node_address_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  // Replies wait here so that a slow consumer does not hold up reception
  // of the following frame.
  mrws_queue #(
    .Depth (JobDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .job_o   (job_head),
    .valid_o (job_valid),
    .full_o  (q_full)
  );

  // The sender walks the head job, computing the reply CRC as the header
  // bytes go out, and releases the job with the eighth byte.
  mrws_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (job_valid),
    .job_i            (job_head),
    .job_pop_o        (job_pop),
    .pop              (pop),
    .empty            (empty),
    .tx_byte_o        (tx_byte_o),
    .last_byte_o      (last_byte_o),
    .node_state_o     (node_state_o),
    .speed_setpoint_o (speed_setpoint_o)
  );

endmodule

/* hdl/mrws_checker.sv */
// Port-level checks for the Modbus RTU register-write slave, bound to the top
// level. Depends on assert_macros.svh.
`include "assert_macros.svh"

module mrws_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [7:0]         tx_byte_o,
  input logic               last_byte_o,
  input logic [1:0]         node_state_o,
  input logic signed [15:0] speed_setpoint_o
);

  // A waiting reply byte holds until taken.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(tx_byte_o), "reply byte changed while stalled")

  // Within a reply the next byte follows without a gap.
  `ASSERT_NEXT(a_no_gap, clk_i, rst_ni, !empty && pop && !last_byte_o, !empty, "gap inside a reply frame")

  // All bytes of one reply report the same node state and setpoint.
  `ASSERT_NEXT(a_snapshot, clk_i, rst_ni, !empty && pop && !last_byte_o, $stable(node_state_o) && $stable(speed_setpoint_o), "state changed inside a reply frame")

endmodule

bind modbus_rtu_write_register_slave mrws_checker u_mrws_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .tx_byte_o        (tx_byte_o),
  .last_byte_o      (last_byte_o),
  .node_state_o     (node_state_o),
  .speed_setpoint_o (speed_setpoint_o)
);

/* tb/modbus_rtu_write_register_slave_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the Modbus RTU register-write slave: models the slave from the
// received bytes and checks every reply byte. Depends on mrws_pkg only.
module modbus_rtu_write_register_slave_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  logic [7:0]         rx_byte_i,
  input  logic               empty,
  input  logic               pop,
  input  logic [7:0]         tx_byte_o,
  input  logic               last_byte_o,
  input  logic [1:0]         node_state_o,
  input  logic signed [15:0] speed_setpoint_o,
  input  logic               node_address_we_i,
  input  logic [7:0]         node_address_i,
  output int                 fail_count_o,
  output int                 replies_pending_o
);

  typedef struct {
    logic [7:0]           data;
    logic                 last;
    mrws_pkg::node_mode_e mode;
    logic signed [15:0]   setpoint;
  } reply_byte_t;

  reply_byte_t replies_due[$];

  logic [mrws_pkg::FRAME_BYTES-1:0][7:0] frame_q;
  logic [2:0]                            pos_q;
  logic [15:0]                           crc_q;
  mrws_pkg::node_mode_e                  mode_q;
  logic signed [15:0]                    setpoint_q;
  logic [7:0]                            addr_q;
  int                                    fails;

  // Bit-serial form of the reflected CRC-16 update.
  function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                  input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ b[i]) ? ((r >> 1) ^ mrws_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // Queues the eight bytes of a reply, with the state as it stands after the frame.
  task automatic queue_reply(input logic [mrws_pkg::HEAD_BYTES-1:0][7:0] head);
    logic [15:0] acc;
    reply_byte_t r;
    acc = mrws_pkg::CRC_INIT;
    for (int i = 0; i < mrws_pkg::FRAME_BYTES; i++) begin
      if (i < mrws_pkg::HEAD_BYTES) begin
        r.data = head[i];
        acc = modbus_crc_step(acc, head[i]);
      end else begin
        r.data = (i == mrws_pkg::HEAD_BYTES) ? acc[7:0] : acc[15:8];
      end
      r.last     = (i == mrws_pkg::FRAME_BYTES - 1);
      r.mode     = mode_q;
      r.setpoint = setpoint_q;
      replies_due.push_back(r);
    end
  endtask

  task automatic queue_error(input logic [7:0] code);
    logic [mrws_pkg::HEAD_BYTES-1:0][7:0] head;
    head    = '0;
    head[0] = frame_q[0];
    head[1] = frame_q[1] | mrws_pkg::EXCEPTION_BIT;
    head[3] = code;
    queue_reply(head);
  endtask

  task automatic absorb_rx_byte(input logic [7:0] b);
    logic [15:0] frame_crc;
    logic [15:0] reg_no;
    logic [15:0] value;
    frame_q[pos_q] = b;
    if (pos_q < mrws_pkg::HEAD_BYTES) begin
      crc_q = modbus_crc_step(crc_q, b);
    end
    if (pos_q != mrws_pkg::FRAME_BYTES - 1) begin
      pos_q++;
    end else begin
      frame_crc = crc_q;
      pos_q     = '0;
      crc_q     = mrws_pkg::CRC_INIT;
      reg_no    = {frame_q[2], frame_q[3]};
      value     = {frame_q[4], frame_q[5]};
      if (frame_q[mrws_pkg::HEAD_BYTES] == frame_crc[7:0] &&
          frame_q[mrws_pkg::HEAD_BYTES+1] == frame_crc[15:8] &&
          frame_q[0] == addr_q && frame_q[1] != mrws_pkg::FUNC_READ) begin
        if (frame_q[1] != mrws_pkg::FUNC_WRITE) begin
          queue_error(mrws_pkg::ERR_FUNCTION);
        end else if (reg_no == mrws_pkg::REG_MODE) begin
          case (value)
            mrws_pkg::CMD_START: begin
              mode_q = mrws_pkg::MODE_OPER;
              queue_reply(frame_q[mrws_pkg::HEAD_BYTES-1:0]);
            end
            mrws_pkg::CMD_STOP: begin
              mode_q = mrws_pkg::MODE_STOP;
              queue_reply(frame_q[mrws_pkg::HEAD_BYTES-1:0]);
            end
            mrws_pkg::CMD_PREOP: begin
              mode_q = mrws_pkg::MODE_PREOP;
              queue_reply(frame_q[mrws_pkg::HEAD_BYTES-1:0]);
            end
            mrws_pkg::CMD_QUIET1, mrws_pkg::CMD_QUIET2: begin
              // Accepted silently: nothing changes.
            end
            default: begin
              queue_error(mrws_pkg::ERR_DATA);
            end
          endcase
        end else if (reg_no == mrws_pkg::REG_SPEED) begin
          setpoint_q = value;
          queue_reply(frame_q[mrws_pkg::HEAD_BYTES-1:0]);
        end else begin
          queue_error(mrws_pkg::ERR_REGISTER);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_byte_t want;
    if (!rst_ni) begin
      frame_q    = '0;
      pos_q      = '0;
      crc_q      = mrws_pkg::CRC_INIT;
      mode_q     = mrws_pkg::MODE_INIT;
      setpoint_q = mrws_pkg::SETPOINT_RESET;
      addr_q     = mrws_pkg::NODE_ADDR_RESET;
      fails      = 0;
      replies_due.delete();
    end else begin
      if (pop && !empty) begin
        if (replies_due.size() == 0) begin
          $display("%0t: reply byte %h with none expected", $time, tx_byte_o);
          fails++;
        end else begin
          want = replies_due.pop_front();
          if (tx_byte_o !== want.data) begin
            $display("%0t: tx_byte expected %h, got %h", $time, want.data, tx_byte_o);
            fails++;
          end
          if (last_byte_o !== want.last) begin
            $display("%0t: last_byte expected %b, got %b", $time, want.last, last_byte_o);
            fails++;
          end
          if (node_state_o !== want.mode) begin
            $display("%0t: node_state expected %0d, got %0d", $time, want.mode, node_state_o);
            fails++;
          end
          if (speed_setpoint_o !== want.setpoint) begin
            $display("%0t: speed_setpoint expected %0d, got %0d", $time, want.setpoint,
                     speed_setpoint_o);
            fails++;
          end
        end
      end
      if (node_address_we_i) begin
        addr_q = node_address_i;
      end
      if (push && !full) begin
        absorb_rx_byte(rx_byte_i);
      end
    end
    fail_count_o      <= fails;
    replies_pending_o <= replies_due.size();
  end

endmodule

/* tb/modbus_rtu_write_register_slave_tb.sv */
`timescale 1ns / 100ps
// Top of the testbench for the Modbus RTU register-write slave: clock, reset,
// frame stimulus and verdict. Depends on mrws_pkg, the slave and its checker.
module modbus_rtu_write_register_slave_tb;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               push              = 1'b0;
  logic [7:0]         rx_byte_i         = '0;
  logic               pop               = 1'b0;
  logic               node_address_we_i = 1'b0;
  logic [7:0]         node_address_i    = '0;
  logic               full;
  logic               empty;
  logic [7:0]         tx_byte_o;
  logic               last_byte_o;
  logic [1:0]         node_state_o;
  logic signed [15:0] speed_setpoint_o;

  int         fail_count;
  int         replies_pending;
  int         bytes_accepted = 0;
  int         reader_stall   = 0;
  bit         calm           = 1'b0; // no idling on either side once set
  bit         sender_steady  = 1'b0; // no gaps within the current frame
  logic [7:0] addr_now       = mrws_pkg::NODE_ADDR_RESET;

  always #2 clk_i = ~clk_i;

  modbus_rtu_write_register_slave dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte_i),
    .empty            (empty),
    .pop              (pop),
    .tx_byte_o        (tx_byte_o),
    .last_byte_o      (last_byte_o),
    .node_state_o     (node_state_o),
    .speed_setpoint_o (speed_setpoint_o),
    .node_address_we_i(node_address_we_i),
    .node_address_i   (node_address_i)
  );

  modbus_rtu_write_register_slave_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte_i),
    .empty            (empty),
    .pop              (pop),
    .tx_byte_o        (tx_byte_o),
    .last_byte_o      (last_byte_o),
    .node_state_o     (node_state_o),
    .speed_setpoint_o (speed_setpoint_o),
    .node_address_we_i(node_address_we_i),
    .node_address_i   (node_address_i),
    .fail_count_o     (fail_count),
    .replies_pending_o(replies_pending)
  );

  // The reply reader stalls in random bursts, and starts none once the run has
  // gone calm. Each stall decision is a single assignment per edge.
  always @(posedge clk_i) begin
    if (reader_stall > 0) begin
      pop          <= 1'b0;
      reader_stall <= reader_stall - 1;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      pop          <= 1'b0;
      reader_stall <= $urandom_range(0, 4);
    end else begin
      pop <= 1'b1;
    end
  end

  // Offers one byte and holds it until the slave takes it. A gap, when one is
  // drawn, lowers push first, so push is never lowered and raised in one step.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && !sender_steady && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    bytes_accepted++;
  endtask

  // Sends one eight-byte frame. Frames are fixed in length, so any stray bytes
  // sent before are first padded out to a frame boundary with random filler;
  // this is what keeps well-formed frames aligned after noise.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                            input logic [15:0] reg_no, input logic [15:0] value,
                            input bit spoil_crc);
    logic [mrws_pkg::HEAD_BYTES-1:0][7:0] head;
    logic [15:0]                          crc;
    sender_steady = ($urandom_range(0, 3) == 0);
    while (bytes_accepted % mrws_pkg::FRAME_BYTES != 0) begin
      send_byte(8'($urandom_range(0, 255)));
    end
    head = {value[7:0], value[15:8], reg_no[7:0], reg_no[15:8], func, addr};
    crc  = mrws_pkg::CRC_INIT;
    for (int i = 0; i < mrws_pkg::HEAD_BYTES; i++) begin
      crc = mrws_pkg::crc16_byte(crc, head[i]);
    end
    if (spoil_crc) begin
      crc ^= 16'd1 << $urandom_range(0, 15);
    end
    for (int i = 0; i < mrws_pkg::HEAD_BYTES; i++) begin
      send_byte(head[i]);
    end
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  // Mostly well-formed write transactions to this node with random content; the
  // rest are foreign addresses, reads, unknown functions, bad CRCs and noise.
  task automatic send_random_frame();
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [15:0] reg_no;
    logic [15:0] value;
    int          pick;
    addr = ($urandom_range(0, 9) < 8) ? addr_now : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      func = mrws_pkg::FUNC_WRITE;
    end else if (pick < 8) begin
      func = mrws_pkg::FUNC_READ;
    end else begin
      func = 8'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 7);
    if (pick < 3) begin
      reg_no = mrws_pkg::REG_MODE;
    end else if (pick < 6) begin
      reg_no = mrws_pkg::REG_SPEED;
    end else begin
      reg_no = 16'($urandom);
    end
    if (reg_no == mrws_pkg::REG_MODE) begin
      case ($urandom_range(0, 6))
        0: value = mrws_pkg::CMD_START;
        1: value = mrws_pkg::CMD_STOP;
        2: value = mrws_pkg::CMD_PREOP;
        3: value = mrws_pkg::CMD_QUIET1;
        4: value = mrws_pkg::CMD_QUIET2;
        5: value = 16'($urandom_range(0, 100));
        default: value = 16'($urandom);
      endcase
    end else begin
      value = 16'($urandom);
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 7)) send_byte(8'($urandom_range(0, 255)));
    end
    send_frame(addr, func, reg_no, value, $urandom_range(0, 7) == 0);
  endtask

  task automatic run_random(input int n_bytes);
    int stop_at;
    stop_at = bytes_accepted + n_bytes;
    while (bytes_accepted < stop_at) begin
      send_random_frame();
    end
  endtask

  // Waits until every predicted reply has been read. A frame that gives no
  // reply may still be in flight, so the wait is padded on both sides; the
  // checker's count is also registered, so it lags behind the reads.
  task automatic wait_for_quiet();
    push <= 1'b0;
    repeat (12) @(posedge clk_i);
    while (replies_pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // The address is only changed with the slave idle and at a frame boundary.
  task automatic write_node_address(input logic [7:0] v);
    wait_for_quiet();
    node_address_we_i <= 1'b1;
    node_address_i    <= v;
    @(posedge clk_i);
    node_address_we_i <= 1'b0;
    addr_now = v;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the reset address: every mode command, the silent
    // ones, the setpoint extremes, each error reply and the dropped frames.
    write_node_address(mrws_pkg::NODE_ADDR_RESET);
    send_frame(addr_now, mrws_pkg::FUNC_WRITE, mrws_pkg::REG_MODE, mrws_pkg::CMD_START, 1'b0);
    send_frame(addr_now, mrws_pkg::FUNC_WRITE, mrws_pkg::REG_MODE, mrws_pkg::CMD_STOP, 1'b0);
    send_frame(addr_now, mrws_pkg::FUNC_WRITE, mrws_pkg::REG_MODE, mrws_pkg::CMD_PREOP, 1'b0);
    send_frame(addr_now, mrws_pkg::FUNC_WRITE, mrws_pkg::REG_MODE, mrws_pkg::CMD_QUIET1,
               1'b0);
    send_frame(addr_now, mrws_pkg::FUNC_WRITE, mrws_pkg::REG_MODE, mrws_pkg::CMD_QUIET2,
               1'b0);
    send_frame(addr_now, mrws_pkg::FUNC_WRITE, mrws_pkg::REG_MODE, 16'hFFFF, 1'b0);
    send_frame(addr_now, mrws_pkg::FUNC_WRITE, mrws_pkg::REG_SPEED, 16'h8000, 1'b0);
    send_frame(addr_now, mrws_pkg::FUNC_WRITE, mrws_pkg::REG_SPEED, 16'h7FFF, 1'b0);
    send_frame(addr_now, mrws_pkg::FUNC_WRITE, mrws_pkg::REG_SPEED, 16'h0000, 1'b0);
    send_frame(addr_now, mrws_pkg::FUNC_WRITE, 16'hFFFF, 16'h0001, 1'b0);
    send_frame(addr_now, mrws_pkg::FUNC_READ, mrws_pkg::REG_MODE, mrws_pkg::CMD_START, 1'b0);
    send_frame(addr_now, 8'hFF, mrws_pkg::REG_MODE, mrws_pkg::CMD_START, 1'b0);
    send_frame(addr_now, 8'h00, mrws_pkg::REG_SPEED, 16'h1234, 1'b0);
    send_frame(addr_now, mrws_pkg::FUNC_WRITE, mrws_pkg::REG_MODE, mrws_pkg::CMD_STOP, 1'b1);
    send_frame(addr_now + 8'd1, mrws_pkg::FUNC_WRITE, mrws_pkg::REG_MODE, mrws_pkg::CMD_STOP,
               1'b0);

    // Random phases at both address extremes and at random addresses.
    write_node_address(8'd0);
    run_random(80);
    write_node_address(8'd255);
    run_random(80);
    write_node_address(8'($urandom_range(1, 254)));
    run_random(80);

    // Last part: no idling on either side.
    write_node_address(8'($urandom_range(0, 255)));
    calm = 1'b1;
    run_random(90);

    wait_for_quiet();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Generous limit: many times the slowest correct run of this stimulus.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/mrws_pkg.sv
hdl/mrws_queue.sv
hdl/mrws_front.sv
hdl/mrws_back.sv
hdl/modbus_rtu_write_register_slave.sv
hdl/mrws_checker.sv
tb/modbus_rtu_write_register_slave_checker.sv
tb/modbus_rtu_write_register_slave_tb.sv
